>>> src/chgw_pkg.sv
// Shared definitions for the gift-wrap convex hull block.
// Holds parameter defaults, the I/O coordinate width and the command codes
// that travel from the front end to the hull walker. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package chgw_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int COORD_BITS_DEF = 16;
   localparam int IO_COORD_W     = 16;
   localparam int QUEUE_DEPTH    = 2;

   typedef enum logic [1:0] {
      OP_STORE,
      OP_STORE_RUN,
      OP_RUN
   } op_type;

endpackage

`default_nettype wire

>>> src/chgw_req_if.sv
// Request channel of the convex hull block: one point per request.
// Depends on chgw_pkg for the coordinate width.
`timescale 1ns / 1ps
`default_nettype none

interface chgw_req_if import chgw_pkg::*; ();

   logic                         valid;
   logic                         ready;
   logic signed [IO_COORD_W-1:0] point_x;
   logic signed [IO_COORD_W-1:0] point_y;
   logic                         last_point;

   modport source (output valid, output point_x, output point_y, output last_point,
                   input ready);
   modport sink (input valid, input point_x, input point_y, input last_point,
                 output ready);

endinterface

`default_nettype wire

>>> src/chgw_rsp_if.sv
// Response channel of the convex hull block: one hull vertex per response.
// Depends on chgw_pkg for the coordinate width.
`timescale 1ns / 1ps
`default_nettype none

interface chgw_rsp_if import chgw_pkg::*; ();

   logic                         valid;
   logic                         ready;
   logic signed [IO_COORD_W-1:0] hull_x;
   logic signed [IO_COORD_W-1:0] hull_y;
   logic                         last_vertex;
   logic                         overrun;

   modport source (output valid, output hull_x, output hull_y, output last_vertex,
                   output overrun, input ready);
   modport sink (input valid, input hull_x, input hull_y, input last_vertex,
                 input overrun, output ready);

endinterface

`default_nettype wire

>>> src/chgw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module chgw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/chgw_front.sv
// Front end of the convex hull block: accepts point requests, resizes the
// coordinates and turns each request into a store and/or walk command.
// Depends on chgw_pkg and chgw_req_if.
`timescale 1ns / 1ps
`default_nettype none

module chgw_front import chgw_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int CNTW = $clog2(MAX_POINTS + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   chgw_req_if.sink                    req,
   output logic                        q_valid,
   input  wire logic                   q_ready,
   output op_type                      q_op,
   output logic        [CNTW-1:0]      q_count,
   output logic signed [COORD_BITS-1:0] q_x,
   output logic signed [COORD_BITS-1:0] q_y
);

   logic [CNTW-1:0] fill_ff, fill_in;
   logic            room;
   logic            accept;

   assign room     = fill_ff < CNTW'(MAX_POINTS);
   assign req.ready = q_ready;
   assign accept   = req.valid && q_ready;
   assign q_valid  = req.valid && (room || req.last_point);
   assign q_count  = room ? CNTW'(fill_ff + 1'b1) : fill_ff;
   assign q_x      = COORD_BITS'({{IO_COORD_W{1'b0}}, req.point_x});
   assign q_y      = COORD_BITS'({{IO_COORD_W{1'b0}}, req.point_y});

   always_comb begin
      if (!req.last_point) begin
         q_op = OP_STORE;
      end else if (room) begin
         q_op = OP_STORE_RUN;
      end else begin
         q_op = OP_RUN;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         if (req.last_point) begin
            fill_in = '0;
         end else if (room) begin
            fill_in = CNTW'(fill_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

>>> src/chgw_queue.sv
// Small register FIFO that decouples the front end from the hull walker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module chgw_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int UW = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic      [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [UW-1:0]    used_ff, used_in;
   logic             push, pop;

   assign in_ready  = used_ff != UW'(DEPTH);
   assign out_valid = used_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      used_in   = used_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         used_in = UW'(used_ff + 1'b1);
      end else if (pop && !push) begin
         used_in = UW'(used_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         used_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

>>> src/chgw_walk.sv
// Back end of the convex hull block: writes points into the point store,
// tracks the start vertex and runs the Jarvis march, visiting the stored
// points in turn. Depends on chgw_pkg, chgw_rsp_if and chgw_ram.
`timescale 1ns / 1ps
`default_nettype none

module chgw_walk import chgw_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int CNTW = $clog2(MAX_POINTS + 1),
   localparam int AW   = $clog2(MAX_POINTS),
   localparam int CW   = COORD_BITS,
   localparam int PRW  = 2 * COORD_BITS + 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   output logic                      q_ready,
   input  wire op_type               q_op,
   input  wire logic        [CNTW-1:0] q_count,
   input  wire logic signed [CW-1:0] q_x,
   input  wire logic signed [CW-1:0] q_y,
   chgw_rsp_if.source                rsp
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_CMP,
      ST_DECIDE
   } state_type;

   state_type               state_ff, state_in;
   logic [CNTW-1:0]         cnt_ff, cnt_in;
   logic [CNTW-1:0]         idx_ff, idx_in;
   logic [CNTW-1:0]         n_ff, n_in;
   logic signed [CW-1:0]    start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic signed [CW-1:0]    cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [CW-1:0]    cand_x_ff, cand_x_in, cand_y_ff, cand_y_in;
   logic signed [CW-1:0]    pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic                    skip_ff, skip_in;
   logic signed [PRW-1:0]   prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic                    out_valid_ff, out_valid_in;
   logic signed [IO_COORD_W-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                    out_last_ff, out_last_in;
   logic                    out_ovr_ff, out_ovr_in;

   logic                    wr_en;
   logic [CNTW-1:0]         wr_idx;
   logic [AW-1:0]           wr_addr;
   logic [AW-1:0]           rd_addr;
   logic [2*CW-1:0]         rd_data;
   logic signed [CW-1:0]    rd_x, rd_y;
   logic signed [CW:0]      dpx, dpy, dqx, dqy;
   logic [CNTW-1:0]         idx_next;
   logic                    scan_end;
   logic                    is_store, new_min, take, closed, limit, out_free;

   chgw_ram #(
      .WIDTH (2 * CW),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({q_x, q_y}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign q_ready  = state_ff == ST_IDLE;
   assign is_store = q_op != OP_RUN;
   assign new_min  = (q_count == CNTW'(1)) || (q_x < start_x_ff);
   assign wr_en    = (state_ff == ST_IDLE) && q_valid && is_store;
   assign wr_idx   = CNTW'(q_count - 1'b1);
   assign wr_addr  = wr_idx[AW-1:0];

   assign idx_next = CNTW'(idx_ff + 1'b1);
   assign scan_end = idx_next == cnt_ff;
   assign rd_addr  = (state_ff == ST_CMP) ? idx_next[AW-1:0] : '0;

   assign rd_x = rd_data[2*CW-1:CW];
   assign rd_y = rd_data[CW-1:0];
   assign dpx  = (CW+1)'(rd_x) - (CW+1)'(cur_x_ff);
   assign dpy  = (CW+1)'(rd_y) - (CW+1)'(cur_y_ff);
   assign dqx  = (CW+1)'(cand_x_ff) - (CW+1)'(cur_x_ff);
   assign dqy  = (CW+1)'(cand_y_ff) - (CW+1)'(cur_y_ff);

   assign take     = (idx_ff == '0) || (!skip_ff && (prod_a_ff <= prod_b_ff));
   assign closed   = (cand_x_ff == start_x_ff) && (cand_y_ff == start_y_ff);
   assign limit    = n_ff >= CNTW'(MAX_POINTS - 1);
   assign out_free = !out_valid_ff || rsp.ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cand_x_in    = cand_x_ff;
      cand_y_in    = cand_y_ff;
      pt_x_in      = rd_x;
      pt_y_in      = rd_y;
      skip_in      = (rd_x == cur_x_ff) && (rd_y == cur_y_ff);
      prod_a_in    = dpx * dqy;
      prod_b_in    = dpy * dqx;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_last_in  = out_last_ff;
      out_ovr_in   = out_ovr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cnt_in = q_count;
               idx_in = '0;
               n_in   = '0;
               if (is_store && new_min) begin
                  start_x_in = q_x;
                  start_y_in = q_y;
               end
               if (q_op != OP_STORE) begin
                  state_in = ST_READ;
                  cur_x_in = (is_store && new_min) ? q_x : start_x_ff;
                  cur_y_in = (is_store && new_min) ? q_y : start_y_ff;
               end
            end
         end
         ST_READ: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (take) begin
               cand_x_in = pt_x_ff;
               cand_y_in = pt_y_ff;
            end
            idx_in   = idx_next;
            state_in = scan_end ? ST_DECIDE : ST_MUL;
         end
         ST_DECIDE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_x_in     = IO_COORD_W'(cur_x_ff);
               out_y_in     = IO_COORD_W'(cur_y_ff);
               out_last_in  = closed || limit;
               out_ovr_in   = !closed && limit;
               if (closed || limit) begin
                  state_in = ST_IDLE;
               end else begin
                  cur_x_in = cand_x_ff;
                  cur_y_in = cand_y_ff;
                  n_in     = CNTW'(n_ff + 1'b1);
                  idx_in   = '0;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         n_ff         <= '0;
         out_valid_ff <= 1'b0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         cand_x_ff    <= '0;
         cand_y_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         n_ff         <= n_in;
         out_valid_ff <= out_valid_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         cand_x_ff    <= cand_x_in;
         cand_y_ff    <= cand_y_in;
         pt_x_ff      <= pt_x_in;
         pt_y_ff      <= pt_y_in;
         skip_ff      <= skip_in;
         prod_a_ff    <= prod_a_in;
         prod_b_ff    <= prod_b_in;
         out_x_ff     <= out_x_in;
         out_y_ff     <= out_y_in;
         out_last_ff  <= out_last_in;
         out_ovr_ff   <= out_ovr_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.hull_x      = out_x_ff;
   assign rsp.hull_y      = out_y_ff;
   assign rsp.last_vertex = out_last_ff;
   assign rsp.overrun     = out_ovr_ff;

endmodule

`default_nettype wire

>>> src/convex_hull_gift_wrap.sv
// Gift-wrap (Jarvis march) convex hull block, top level.
// Each request carries one signed point; last_point closes the cloud.
// Points are stored at one per cycle through a two-entry command queue.
// The request that closes the cloud starts the hull walk; while it runs,
// the queue fills and then request ready drops until the walk ends.
// The walk starts at the first stored point with the least x. Each step
// scans all N stored points in turn, each through a store read, a multiply
// and a compare, before the next hull vertex is chosen.
// Each response is one hull vertex in discovery order; last_vertex marks the
// final one, and overrun marks a walk cut off after MAX_POINTS vertices.
// Responses sit in an output register; a stalled receiver holds the walk
// at its next step and never loses or repeats a vertex.
// Reset empties the queue and point counts and drops a response in flight.
// Depends on chgw_pkg, the channel interfaces and the chgw_* modules.
`timescale 1ns / 1ps
`default_nettype none

module convex_hull_gift_wrap import chgw_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   chgw_req_if.sink    req_ch,
   chgw_rsp_if.source  rsp_ch
);

   localparam int CNTW = $clog2(MAX_POINTS + 1);
   localparam int OPW  = $bits(op_type);
   localparam int QW   = OPW + CNTW + 2 * COORD_BITS;

   logic                         f_valid, f_ready;
   op_type                       f_op;
   logic [CNTW-1:0]              f_count;
   logic signed [COORD_BITS-1:0] f_x, f_y;
   logic [QW-1:0]                f_data;

   logic                         w_valid, w_ready;
   logic [QW-1:0]                w_data;
   op_type                       w_op;
   logic [CNTW-1:0]              w_count;
   logic signed [COORD_BITS-1:0] w_x, w_y;

   chgw_front #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .q_valid (f_valid),
      .q_ready (f_ready),
      .q_op    (f_op),
      .q_count (f_count),
      .q_x     (f_x),
      .q_y     (f_y)
   );

   assign f_data = {f_op, f_count, f_x, f_y};

   chgw_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (w_valid),
      .out_ready (w_ready),
      .out_data  (w_data)
   );

   assign w_op    = op_type'(w_data[QW-1 -: OPW]);
   assign w_count = w_data[2*COORD_BITS +: CNTW];
   assign w_x     = w_data[COORD_BITS +: COORD_BITS];
   assign w_y     = w_data[0 +: COORD_BITS];

   chgw_walk #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_walk (
      .clock   (clock),
      .reset   (reset),
      .q_valid (w_valid),
      .q_ready (w_ready),
      .q_op    (w_op),
      .q_count (w_count),
      .q_x     (w_x),
      .q_y     (w_y),
      .rsp     (rsp_ch)
   );

endmodule

`default_nettype wire

>>> src/chgw_check.sv
// Port-level checker for the convex hull block, bound to the top level.
// Depends on chgw_pkg for the coordinate width.
`timescale 1ns / 1ps
`default_nettype none

module chgw_check import chgw_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [IO_COORD_W-1:0] hull_x,
   input wire logic [IO_COORD_W-1:0] hull_y,
   input wire logic                  last_vertex,
   input wire logic                  overrun
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Response withdrawn before it was taken.");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({hull_x, hull_y, last_vertex, overrun}))
      else $error("Response payload changed while stalled.");

   a_overrun_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && overrun |-> last_vertex)
      else $error("Overrun flagged on a vertex that is not the last one.");

   a_reset_quiet : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Response valid right after reset.");

endmodule

bind convex_hull_gift_wrap chgw_check u_chgw_check (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .hull_x      (rsp_ch.hull_x),
   .hull_y      (rsp_ch.hull_y),
   .last_vertex (rsp_ch.last_vertex),
   .overrun     (rsp_ch.overrun)
);

`default_nettype wire

>>> sim/convex_hull_gift_wrap_checker.sv
// Watches both channels of the convex hull block, predicts the hull of each
// point cloud and compares every returned vertex against that prediction.
// Depends on chgw_pkg and the chgw_req_if / chgw_rsp_if interfaces.
`timescale 1ns / 1ps

module convex_hull_gift_wrap_checker import chgw_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   chgw_req_if         req_ch,
   chgw_rsp_if         rsp_ch,
   output int unsigned mismatch_count,
   output int unsigned hulls_pending
);

   localparam int CLOUD_CAP = MAX_POINTS_DEF;

   typedef struct packed {
      logic signed [IO_COORD_W-1:0] x;
      logic signed [IO_COORD_W-1:0] y;
   } point_t;

   typedef struct packed {
      point_t pos;
      logic   last_vertex;
      logic   overrun;
   } vertex_t;

   point_t      cloud [CLOUD_CAP];
   int unsigned cloud_size;
   vertex_t     pending_vertices [$];
   vertex_t     due;

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   // A point takes over the candidate when it lies on or left of the ray from c to q.
   function automatic bit takes_over(point_t p, point_t q, point_t c);
      longint px, py, qx, qy;
      px = longint'($signed(p.x)) - longint'($signed(c.x));
      py = longint'($signed(p.y)) - longint'($signed(c.y));
      qx = longint'($signed(q.x)) - longint'($signed(c.x));
      qy = longint'($signed(q.y)) - longint'($signed(c.y));
      return (px * qy) <= (py * qx);
   endfunction

   function automatic void append_vertex(point_t pos);
      vertex_t v;
      v = '{pos: pos, last_vertex: 1'b0, overrun: 1'b0};
      pending_vertices = {pending_vertices, v};
   endfunction

   function automatic void wrap_cloud();
      point_t anchor, here, best;
      int     emitted;
      bit     cut;
      anchor = cloud[0];
      for (int i = 1; i < cloud_size; i++) begin
         if ($signed(cloud[i].x) < $signed(anchor.x)) begin
            anchor = cloud[i];
         end
      end
      append_vertex(anchor);
      emitted = 1;
      here = anchor;
      cut = 1'b0;
      while (1'b1) begin
         best = cloud[0];
         for (int i = 0; i < cloud_size; i++) begin
            if (cloud[i] != here && takes_over(cloud[i], best, here)) begin
               best = cloud[i];
            end
         end
         here = best;
         if (here == anchor) begin
            break;
         end
         if (emitted >= CLOUD_CAP) begin
            cut = 1'b1;
            break;
         end
         append_vertex(here);
         emitted++;
      end
      pending_vertices[pending_vertices.size() - 1].last_vertex = 1'b1;
      pending_vertices[pending_vertices.size() - 1].overrun = cut;
      cloud_size = 0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cloud_size = 0;
         mismatch_count = 0;
         pending_vertices.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            if (cloud_size < CLOUD_CAP) begin
               cloud[cloud_size] = '{x: req_ch.point_x, y: req_ch.point_y};
               cloud_size++;
            end
            if (req_ch.last_point) begin
               wrap_cloud();
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_vertices.size() == 0) begin
               report_mismatch($sformatf("unexpected vertex (%0d, %0d)",
                                         rsp_ch.hull_x, rsp_ch.hull_y));
            end else begin
               due = pending_vertices.pop_front();
               if (rsp_ch.hull_x !== due.pos.x) begin
                  report_mismatch($sformatf("hull_x got %0d, expected %0d",
                                            rsp_ch.hull_x, due.pos.x));
               end
               if (rsp_ch.hull_y !== due.pos.y) begin
                  report_mismatch($sformatf("hull_y got %0d, expected %0d",
                                            rsp_ch.hull_y, due.pos.y));
               end
               if (rsp_ch.last_vertex !== due.last_vertex) begin
                  report_mismatch($sformatf("last_vertex got %b, expected %b",
                                            rsp_ch.last_vertex, due.last_vertex));
               end
               if (rsp_ch.overrun !== due.overrun) begin
                  report_mismatch($sformatf("overrun got %b, expected %b",
                                            rsp_ch.overrun, due.overrun));
               end
            end
         end
      end
      hulls_pending = pending_vertices.size();
   end

endmodule

>>> sim/convex_hull_gift_wrap_tb.sv
// Top of the convex hull testbench: drives point clouds into the block,
// throttles both channels and reports the verdict from the checker.
// Depends on chgw_pkg, the channel interfaces, the block and the checker.
`timescale 1ns / 1ps

module convex_hull_gift_wrap_tb import chgw_pkg::*;;

   localparam int RANDOM_POINTS = 230;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int HOLD_CYCLES   = 400;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned mismatch_count;
   int unsigned hulls_pending;
   int unsigned cycle_count = 0;
   int          points_sent = 0;
   int          send_idle_pct = 31;
   int          recv_idle_pct = 71;
   logic        hold_armed = 1'b0;
   logic        hold_taken = 1'b0;
   int          hold_left = 0;
   bit          big_cloud_done = 1'b0;

   chgw_req_if req_ch ();
   chgw_rsp_if rsp_ch ();

   convex_hull_gift_wrap uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   convex_hull_gift_wrap_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .hulls_pending  (hulls_pending)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.point_x    <= x;
      req_ch.point_y    <= y;
      req_ch.last_point <= last;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      points_sent++;
   endtask

   task automatic send_cloud(input int size);
      int          shape, bx, by, dx, dy, k;
      logic signed [15:0] x, y;
      shape = $urandom_range(3);
      bx = int'($urandom_range(2000)) - 1000;
      by = int'($urandom_range(2000)) - 1000;
      dx = int'($urandom_range(8)) - 4;
      dy = int'($urandom_range(8)) - 4;
      for (int i = 0; i < size; i++) begin
         if (shape == 2) begin
            x = 16'(int'($urandom_range(6)) - 3);
            y = 16'(int'($urandom_range(6)) - 3);
         end else if (shape == 3) begin
            k = $urandom_range(20);
            x = 16'(bx + k * dx);
            y = 16'(by + k * dy);
         end else begin
            x = 16'($urandom);
            y = 16'($urandom);
         end
         send_point(x, y, i == size - 1);
      end
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_armed && !hold_taken) begin
            hold_left = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
         @(negedge clock);
      end
   end

   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.point_x    = '0;
      req_ch.point_y    = '0;
      req_ch.last_point = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A lone point at the coordinate extremes.
      send_point(-16'sd32768, 16'sd32767, 1'b1);
      // All points coincide.
      send_point(16'sd5, 16'sd5, 1'b0);
      send_point(16'sd5, 16'sd5, 1'b0);
      send_point(16'sd5, 16'sd5, 1'b1);
      // Corners of the full coordinate range with an interior point.
      send_point(16'sd32767, 16'sd32767, 1'b0);
      send_point(-16'sd32768, -16'sd32768, 1'b0);
      send_point(16'sd32767, -16'sd32768, 1'b0);
      send_point(-16'sd32768, 16'sd32767, 1'b0);
      send_point(16'sd0, 16'sd0, 1'b1);
      // Points on one diagonal line.
      send_point(16'sd0, 16'sd0, 1'b0);
      send_point(16'sd1, 16'sd1, 1'b0);
      send_point(16'sd2, 16'sd2, 1'b0);
      send_point(16'sd3, 16'sd3, 1'b1);
      // Points on one vertical line, so the least x is shared.
      send_point(16'sd0, -16'sd3, 1'b0);
      send_point(16'sd0, 16'sd2, 1'b0);
      send_point(16'sd0, 16'sd0, 1'b1);
      // Triangle with interior and edge points.
      send_point(-16'sd10, 16'sd0, 1'b0);
      send_point(16'sd10, 16'sd0, 1'b0);
      send_point(16'sd0, 16'sd10, 1'b0);
      send_point(16'sd0, 16'sd2, 1'b0);
      send_point(16'sd0, 16'sd0, 1'b0);
      send_point(16'sd5, 16'sd5, 1'b1);

      hold_armed <= 1'b1;
      while (points_sent < RANDOM_POINTS) begin
         if (points_sent >= 170) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (points_sent >= 90) begin
            send_idle_pct = 71;
            recv_idle_pct = 31;
         end
         if (points_sent >= 90 && !big_cloud_done) begin
            big_cloud_done = 1'b1;
            send_cloud(MAX_POINTS_DEF + 6);
         end else begin
            send_cloud($urandom_range(1, 12));
         end
      end
      req_ch.valid <= 1'b0;

      while (hulls_pending != 0) begin
         @(negedge clock);
      end
      repeat (40) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
